@@ rtl/core/pecb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pecb_pkg;
    localparam int NumCounters = 44;
    localparam int IdxW = 6;
    localparam int EvW = 44;

    typedef enum logic {
        t_op_sample = 1'b0,
        t_op_read   = 1'b1
    } t_opcode;

    typedef struct packed {
        logic            is_read;
        logic [IdxW-1:0] idx;
        logic [EvW-1:0]  events;
    } t_cmd;

    localparam logic [2:0] IcIdle = 3'b000;
    localparam logic [2:0] IcWalk = 3'b100;
    localparam logic [2:0] DcIdle = 3'b000;
    localparam logic [2:0] DcHit  = 3'b001;
    localparam logic [2:0] DcMiss = 3'b010;
    localparam logic [2:0] DcWalk = 3'b100;
endpackage
`default_nettype wire

@@ rtl/core/pecb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Classifies one sample into a vector of counter increments.
module pecb_front #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int RENAME_DEPTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic                       i_is_read,
    input  wire logic [pecb_pkg::IdxW-1:0]  i_idx,
    input  wire logic [5:0]                 i_cf,
    input  wire logic [15:0]                i_inst,
    input  wire logic [4:0]                 i_ff,
    input  wire logic [7:0]                 i_rs,
    input  wire logic [7:0]                 i_ioq,
    input  wire logic [4:0]                 i_bf,
    input  wire logic [7:0]                 i_rnv,
    input  wire logic [2:0]                 i_tail,
    input  wire logic [5:0]                 i_cs,
    input  wire logic [4:0]                 i_lf,
    input  wire logic [3:0]                 i_flush_len,
    output pecb_pkg::t_cmd                  o_cmd,
    output logic                            o_drop
);
    localparam int QB = (QUEUE_DEPTH > 8) ? 8 : QUEUE_DEPTH;
    localparam int RB = (RENAME_DEPTH > 8) ? 8 : RENAME_DEPTH;

    logic [3:0] r_drain, n_drain;
    logic [3:0] r_pfull, n_pfull;
    logic [2:0] r_pic, r_pdc;
    logic [pecb_pkg::EvW-1:0] ev;
    logic v, v2, br, jp, jr, fl, stall, ready, rnu, ib, rsf_full, ioq_is_full, rob_is_full;
    logic cb, anyb, thit;
    logic [2:0] ic, dc, f3;

    always_comb begin
        v = i_cf[0]; v2 = i_cf[1]; br = i_cf[2]; jp = i_cf[3]; jr = i_cf[4]; fl = i_cf[5];
        stall = i_ff[1]; ready = i_bf[2]; thit = i_lf[0];
        ic = i_cs[2:0]; dc = i_cs[5:3];
        // tail beyond the rename depth reads as an empty entry
        rnu = ({29'd0, i_tail} < RB) ? i_rnv[i_tail] : 1'b0;
        ib = (ic == 3'd1) || (ic == 3'd2) || (ic == 3'd6) || (ic == 3'd7) || (ic == 3'd4);
        f3 = i_inst[15:13];
        cb = v && (i_inst[1:0] == 2'b01) && (f3 == 3'd6 || f3 == 3'd7 || f3 == 3'd5);
        anyb = v && (br || jp || jr);
        // a queue deeper than the 8-bit mask can never show as full
        rsf_full = (QUEUE_DEPTH > 8) ? 1'b0 : &i_rs[QB-1:0];
        ioq_is_full = (QUEUE_DEPTH > 8) ? 1'b0 : &i_ioq[QB-1:0];
        rob_is_full = rnu && !ready;
        n_drain = fl ? i_flush_len : ((r_drain != 4'd0) ? r_drain - 4'd1 : 4'd0);
        n_pfull = {i_bf[4], rob_is_full, ioq_is_full, rsf_full};
        ev = '0;
        ev[0]  = 1'b1;
        ev[1]  = anyb;   // second increment from compressed branch handled in back end
        ev[2]  = anyb && fl;
        ev[3]  = v && fl && br;
        ev[4]  = v && fl && jp;
        ev[5]  = v && fl && jr;
        ev[6]  = i_ff[0];
        ev[7]  = stall;
        ev[8]  = i_ff[2];
        ev[9]  = rob_is_full;
        ev[10] = (i_rs != 8'd0) && !i_bf[0];
        ev[11] = (i_ioq != 8'd0) && !i_bf[1];
        ev[12] = (dc == pecb_pkg::DcMiss) && !thit;
        ev[13] = i_bf[3];
        ev[14] = i_ff[3];
        ev[15] = i_lf[3] && i_lf[1];
        ev[16] = i_lf[3] && i_lf[2];
        ev[17] = v && v2;
        ev[18] = !v;
        ev[19] = stall && ib;
        ev[20] = stall && !ib && (n_drain != 4'd0);
        ev[21] = stall && !ib && (n_drain == 4'd0);
        ev[22] = rsf_full;
        ev[23] = rsf_full && !r_pfull[0];
        ev[24] = ioq_is_full;
        ev[25] = ioq_is_full && !r_pfull[1];
        ev[26] = rob_is_full;
        ev[27] = rob_is_full && !r_pfull[2];
        ev[28] = i_bf[4];
        ev[29] = i_bf[4] && !r_pfull[3];
        ev[30] = v && v2;
        ev[31] = v && !v2;
        ev[32] = (n_drain != 4'd0);
        ev[33] = (n_drain == 4'd0) && rnu && ready;
        ev[34] = (n_drain == 4'd0) && rnu && !ready;
        ev[35] = (n_drain == 4'd0) && !rnu;
        ev[36] = (r_pic == pecb_pkg::IcIdle) && ib;
        ev[37] = ib;
        ev[38] = (dc == pecb_pkg::DcHit) && thit;
        ev[39] = (r_pdc == pecb_pkg::DcHit) && (dc == pecb_pkg::DcMiss);
        ev[40] = (dc == pecb_pkg::DcMiss);
        ev[41] = (ic == pecb_pkg::IcWalk);
        ev[42] = (dc == pecb_pkg::DcWalk) && i_lf[4];
        ev[43] = (dc == pecb_pkg::DcWalk) && !i_lf[4];
    end

    // compressed branch bumps counter 1 a second time, and counter 2 too on a flush; flagged via idx bits
    assign o_cmd.is_read = i_is_read;
    assign o_cmd.idx     = i_is_read ? i_idx : {4'd0, cb && fl, cb};
    assign o_cmd.events  = ev;
    assign o_drop        = !i_is_read && i_ff[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= '0; r_pfull <= '0; r_pic <= '0; r_pdc <= '0;
        end else if (i_fire && !i_is_read && !i_ff[4]) begin
            r_drain <= n_drain; r_pfull <= n_pfull; r_pic <= ic; r_pdc <= dc;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/pecb_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue between front and back.
module pecb_fifo (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  pecb_pkg::t_cmd i_data,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_empty,
    output pecb_pkg::t_cmd o_data
);
    pecb_pkg::t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/pecb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Counter bank: applies increment vectors, serves reads into an output register.
module pecb_back #(
    parameter int COUNTER_WIDTH = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  pecb_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  wire logic                      i_tready,
    output logic [63:0]                    o_value,
    output logic [pecb_pkg::IdxW-1:0]      o_idx
);
    logic [COUNTER_WIDTH-1:0] r_cnt [pecb_pkg::NumCounters];
    logic r_ov;
    logic can_out;

    assign can_out = !r_ov || i_tready;
    assign o_pop = i_valid && (!i_cmd.is_read || can_out);
    assign o_tvalid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pecb_pkg::NumCounters; k++) r_cnt[k] <= '0;
        end else if (o_pop && !i_cmd.is_read) begin
            for (int k = 0; k < pecb_pkg::NumCounters; k++) begin
                if (k == 1)
                    r_cnt[k] <= r_cnt[k] + COUNTER_WIDTH'(i_cmd.events[k])
                                + COUNTER_WIDTH'(i_cmd.idx[0]);
                else if (k == 2)
                    r_cnt[k] <= r_cnt[k] + COUNTER_WIDTH'(i_cmd.events[k])
                                + COUNTER_WIDTH'(i_cmd.idx[1]);
                else
                    r_cnt[k] <= r_cnt[k] + COUNTER_WIDTH'(i_cmd.events[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (o_pop && i_cmd.is_read) r_ov <= 1'b1;
        else if (i_tready) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.is_read) begin
            o_idx <= i_cmd.idx;
            o_value <= ({26'd0, i_cmd.idx} < pecb_pkg::NumCounters)
                ? 64'(r_cnt[i_cmd.idx]) : 64'd0;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/pipeline_event_counter_bank_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline event counter bank: 44 wrapping performance counters.
// Slave stream carries items: tuser = opcode (0 sample, 1 read);
// tdata packs counter_index, commit_flags, commit_inst_low, frontend_flags,
// rs/ioq masks, backend_flags, rename mask and tail, cache_states, lsu_flags.
// A sample updates the counters and yields nothing; a read yields one master
// transfer with counter_value (tdata[63:0]) and the index echo (tdata[69:64]).
// Throughput is one item per cycle unless the receiver stalls. The front stage
// classifies a sample into an increment vector and writes it to a two-entry queue;
// the counter bank pops one entry per cycle, holding a read while the output
// register is full. An accepted read passes through the queue into the output
// register and transfers from there. When the receiver stalls, the output
// register and then the queue fill and s_axis_tready drops.
// Reset clears all counters, history state and sets flush_window_length to 5.
// APB: register 0 at address 0 is flush_window_length (4 bits).
module pipeline_event_counter_bank_core #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int RENAME_DEPTH  = 8,
    parameter int COUNTER_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // idx[5:0] cf[11:6] inst[27:12] ff[32:28] rs[40:33] ioq[48:41] bf[53:49]
    // rnv[61:54] tail[64:62] cs[70:65] lf[75:71], zero pad to 80
    input  wire logic [79:0] s_axis_tdata,
    // opcode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // counter_value[63:0] counter_index_echo[69:64], pad to 72
    output logic [71:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [3:0] r_flen;
    logic fire, drop, full, empty, pop;
    pecb_pkg::t_cmd cmd, qcmd;
    logic [63:0] value;
    logic [pecb_pkg::IdxW-1:0] idx;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {28'd0, r_flen} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_flen <= 4'd5;
        else if (psel && penable && pwrite && paddr == 1'b0) r_flen <= pwdata[3:0];
    end

    assign s_axis_tready = !full;
    assign fire = s_axis_tvalid && s_axis_tready;

    pecb_front #(.QUEUE_DEPTH(QUEUE_DEPTH), .RENAME_DEPTH(RENAME_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(fire),
        .i_is_read(s_axis_tuser == pecb_pkg::t_op_read),
        .i_idx(s_axis_tdata[5:0]), .i_cf(s_axis_tdata[11:6]),
        .i_inst(s_axis_tdata[27:12]), .i_ff(s_axis_tdata[32:28]),
        .i_rs(s_axis_tdata[40:33]), .i_ioq(s_axis_tdata[48:41]),
        .i_bf(s_axis_tdata[53:49]), .i_rnv(s_axis_tdata[61:54]),
        .i_tail(s_axis_tdata[64:62]), .i_cs(s_axis_tdata[70:65]),
        .i_lf(s_axis_tdata[75:71]), .i_flush_len(r_flen),
        .o_cmd(cmd), .o_drop(drop)
    );

    pecb_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fire && !drop), .i_data(cmd),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(qcmd)
    );

    pecb_back #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(!empty), .i_cmd(qcmd),
        .o_pop(pop), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_value(value), .o_idx(idx)
    );

    assign m_axis_tdata = {2'b00, idx, value};

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !drop) |-> (!full || pop)) else $error("push into full queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
endmodule
`default_nettype wire

@@ verif/pipeline_event_counter_bank_core_test.sv @@
`timescale 1ns / 1ps
module pipeline_event_counter_bank_core_test;

    // probe item as it sits in s_axis_tdata, lowest field last
    typedef struct packed {
        logic [3:0]  pad;
        logic [4:0]  lf;
        logic [5:0]  cs;
        logic [2:0]  tail;
        logic [7:0]  rnv;
        logic [4:0]  bf;
        logic [7:0]  ioq;
        logic [7:0]  rs;
        logic [4:0]  ff;
        logic [15:0] inst;
        logic [5:0]  cf;
        logic [5:0]  idx;
    } t_probe;

    typedef struct {
        logic [63:0] value;
        logic [5:0]  idx;
    } t_readback;

    class counter_scoreboard;
        logic [63:0] ctr[pecb_pkg::NumCounters];
        logic [3:0]  drain;
        logic [3:0]  prev_full;
        logic [2:0]  prev_ic;
        logic [2:0]  prev_dc;
        logic [3:0]  window;
        t_readback   pending[$];
        int          errors;

        function new();
            foreach (ctr[i]) ctr[i] = '0;
            drain = '0;
            prev_full = '0;
            prev_ic = pecb_pkg::IcIdle;
            prev_dc = pecb_pkg::DcIdle;
            window = 4'd5;
            errors = 0;
        endfunction

        function void bump(int i, bit c);
            if (c) ctr[i] = ctr[i] + 64'd1;
        endfunction

        function void apply_sample(t_probe p);
            bit v, v2, br, jp, jr, fl, stall, ready, rnu, ib, anyb, cb;
            bit rs_full, ioq_is_full, rob_is_full, sqfull, thit, rav, swalk;
            logic [2:0] ic, dc, f3;
            if (p.ff[4]) return;
            {fl, jr, jp, br, v2, v} = p.cf;
            stall = p.ff[1];
            ready = p.bf[2];
            sqfull = p.bf[4];
            thit = p.lf[0];
            rav = p.lf[3];
            swalk = p.lf[4];
            rnu = p.rnv[p.tail];
            ic = p.cs[2:0];
            dc = p.cs[5:3];
            ib = (ic == 3'd1) || (ic == 3'd2) || (ic == 3'd6) || (ic == 3'd7) || (ic == 3'd4);
            bump(0, 1);
            if (v) begin
                anyb = br || jp || jr;
                bump(1, anyb);
                bump(2, anyb && fl);
                bump(3, fl && br);
                bump(4, fl && jp);
                bump(5, fl && jr);
                if (p.inst[1:0] == 2'b01) begin
                    // compressed branch/jump opcodes in quadrant one
                    f3 = p.inst[15:13];
                    cb = (f3 == 3'd6) || (f3 == 3'd7) || (f3 == 3'd5);
                    bump(1, cb);
                    bump(2, cb && fl);
                end
            end
            bump(6, p.ff[0]);
            bump(7, stall);
            bump(8, p.ff[2]);
            bump(9, rnu && !ready);
            bump(10, p.rs != 0 && !p.bf[0]);
            bump(11, p.ioq != 0 && !p.bf[1]);
            bump(12, dc == pecb_pkg::DcMiss && !thit);
            bump(13, p.bf[3]);
            bump(14, p.ff[3]);
            bump(15, rav && p.lf[1]);
            bump(16, rav && p.lf[2]);
            bump(17, v && v2);
            bump(18, !v);
            if (fl) drain = window;
            else if (drain != 0) drain = drain - 4'd1;
            if (stall) begin
                if (ib) bump(19, 1);
                else if (drain != 0) bump(20, 1);
                else bump(21, 1);
            end
            rs_full = &p.rs;
            ioq_is_full = &p.ioq;
            rob_is_full = rnu && !ready;
            bump(22, rs_full);
            bump(23, rs_full && !prev_full[0]);
            bump(24, ioq_is_full);
            bump(25, ioq_is_full && !prev_full[1]);
            bump(26, rob_is_full);
            bump(27, rob_is_full && !prev_full[2]);
            bump(28, sqfull);
            bump(29, sqfull && !prev_full[3]);
            prev_full = {sqfull, rob_is_full, ioq_is_full, rs_full};
            if (v && v2) bump(30, 1);
            else if (v) bump(31, 1);
            if (drain != 0) bump(32, 1);
            else if (rnu && ready) bump(33, 1);
            else if (rnu) bump(34, 1);
            else bump(35, 1);
            bump(36, prev_ic == pecb_pkg::IcIdle && ib);
            bump(37, ib);
            prev_ic = ic;
            bump(38, dc == pecb_pkg::DcHit && thit);
            bump(39, prev_dc == pecb_pkg::DcHit && dc == pecb_pkg::DcMiss);
            bump(40, dc == pecb_pkg::DcMiss);
            prev_dc = dc;
            bump(41, ic == pecb_pkg::IcWalk);
            if (dc == pecb_pkg::DcWalk) begin
                if (swalk) bump(42, 1);
                else bump(43, 1);
            end
        endfunction

        function void note_item(logic op, t_probe p);
            t_readback r;
            if (op == pecb_pkg::t_op_sample) begin
                apply_sample(p);
            end else begin
                r.idx = p.idx;
                r.value = (p.idx < pecb_pkg::NumCounters) ? ctr[p.idx] : 64'd0;
                pending.push_back(r);
            end
        endfunction

        function void check_result(logic [71:0] d);
            t_readback r;
            if (pending.size() == 0) begin
                $error("unexpected transfer: counter_index_echo %0d", d[69:64]);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (d[63:0] !== r.value) begin
                $error("counter_value: expected %0h, actual %0h", r.value, d[63:0]);
                errors++;
            end
            if (d[69:64] !== r.idx) begin
                $error("counter_index_echo: expected %0d, actual %0d", r.idx, d[69:64]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    counter_scoreboard sb;
    bit idling;
    int stall_left;
    int quiet_cycles;

    pipeline_event_counter_bank_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(s_axis_tuser, t_probe'(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 2000) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send(logic op, t_probe p);
        int n;
        if (idling && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 7);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= p;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_window(logic [3:0] w);
        drain_results();
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {28'd0, w};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.window = w;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(0, 3))
            0: return 8'hFF;
            1: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_probe random_probe();
        t_probe p;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        p = raw[79:0];
        p.pad = '0;
        p.idx = $urandom_range(0, 9) == 0 ? 6'($urandom_range(44, 63)) : 6'($urandom_range(0, 43));
        // mostly live samples; a few taken while the core is held in reset
        p.ff[4] = ($urandom_range(0, 9) == 0);
        p.rs = pick_mask();
        p.ioq = pick_mask();
        p.rnv = pick_mask();
        if ($urandom_range(0, 1)) p.inst[1:0] = 2'b01;
        // long runs without flushes let drain windows expire
        p.cf[5] = ($urandom_range(0, 5) == 0);
        return p;
    endfunction

    task automatic random_phase(int n);
        t_probe p;
        for (int k = 0; k < n; k++) begin
            p = random_probe();
            send($urandom_range(0, 2) == 0 ? pecb_pkg::t_op_read : pecb_pkg::t_op_sample, p);
        end
    endtask

    initial begin
        t_probe p;
        sb = new();
        idling = 1'b1;
        stall_left = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, compressed branches, cache transitions, odd indexes
        p = '1; p.pad = '0;
        send(pecb_pkg::t_op_sample, p);     // core in reset, ignored
        p.ff[4] = 1'b0;
        send(pecb_pkg::t_op_sample, p);     // everything set
        p = '0;
        send(pecb_pkg::t_op_sample, p);
        p.cf = 6'b100001; p.inst = 16'hC001;
        send(pecb_pkg::t_op_sample, p);
        p.inst = 16'hE001; p.cf = 6'b000001;
        send(pecb_pkg::t_op_sample, p);
        p.inst = 16'hA001; p.cf = 6'b100011;
        send(pecb_pkg::t_op_sample, p);
        p.inst = 16'h8001; p.cf = 6'b111101; p.ff = 5'b00010;
        send(pecb_pkg::t_op_sample, p);
        p = '0; p.ff = 5'b00010; p.cs = 6'b001_001;
        send(pecb_pkg::t_op_sample, p);
        p.cs = 6'b010_100; p.lf = 5'b10000;
        send(pecb_pkg::t_op_sample, p);
        p.cs = 6'b100_110; p.lf = 5'b01110; p.rs = 8'hFF; p.ioq = 8'hFF;
        send(pecb_pkg::t_op_sample, p);
        p.cs = 6'b100_111; p.lf = 5'b01001; p.rnv = 8'h80; p.tail = 3'd7;
        send(pecb_pkg::t_op_sample, p);
        p.cs = 6'b011_011; p.rnv = 8'h80; p.bf = 5'b10100;
        send(pecb_pkg::t_op_sample, p);
        p.cs = 6'b101_101; p.bf = 5'b11011; p.ff = 5'b01101;
        send(pecb_pkg::t_op_sample, p);
        p = '0; p.idx = 6'd0;
        send(pecb_pkg::t_op_read, p);
        p.idx = 6'd43;
        send(pecb_pkg::t_op_read, p);
        p.idx = 6'd44;
        send(pecb_pkg::t_op_read, p);
        p.idx = 6'd63;
        send(pecb_pkg::t_op_read, p);
        for (int i = 0; i < pecb_pkg::NumCounters; i++) begin
            p.idx = 6'(i);
            send(pecb_pkg::t_op_read, p);
        end

        random_phase(350);
        write_window(4'd0);
        random_phase(350);
        write_window(4'd15);
        random_phase(350);
        write_window(4'($urandom_range(1, 14)));
        random_phase(350);
        write_window(4'd5);
        idling = 1'b0;
        random_phase(250);

        drain_results();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
